>>> src/pfrl_pkg.sv
// Shared types and constants for the packet filter with source rate limit.
`timescale 1ns / 1ps

package pfrl_pkg;

	// Input item opcodes
	localparam logic [1:0] OP_BYTE     = 2'd0;
	localparam logic [1:0] OP_RULE_WR  = 2'd1;
	localparam logic [1:0] OP_RULE_DEL = 2'd2;

	// Drop causes
	localparam logic [2:0] CAUSE_NONE  = 3'd0;
	localparam logic [2:0] CAUSE_RATE  = 3'd1;
	localparam logic [2:0] CAUSE_RULE  = 3'd2;
	localparam logic [2:0] CAUSE_SYN   = 3'd3;
	localparam logic [2:0] CAUSE_ECHO  = 3'd4;

	// Header constants
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [3:0]  IP_VERSION_4   = 4'd4;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  PROTO_ICMP     = 8'd1;
	localparam logic [7:0]  ICMP_ECHO_REQ  = 8'd8;

	// Byte offsets within the frame
	localparam logic [15:0] POS_ETYPE_HI  = 16'd12;
	localparam logic [15:0] POS_ETYPE_LO  = 16'd13;
	localparam logic [15:0] POS_IP_VL     = 16'd14;
	localparam logic [15:0] POS_IP_PROTO  = 16'd23;
	localparam logic [15:0] POS_SRC_FIRST = 16'd26;
	localparam logic [15:0] POS_SRC_LAST  = 16'd29;
	localparam logic [15:0] POS_DST_FIRST = 16'd30;
	localparam logic [15:0] POS_DST_LAST  = 16'd33;
	localparam logic [15:0] MIN_IP_LEN    = 16'd34;
	localparam logic [15:0] TCP_FLAG_OFS  = 16'd13;
	localparam logic [15:0] TCP_HDR_LEN   = 16'd20;
	localparam logic [15:0] ICMP_HDR_LEN  = 16'd8;
	localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

	// Configuration reset
	localparam logic [39:0] WINDOW_RESET = 40'd1000000000;

	// Queue depths
	localparam int JOB_Q_DEPTH = 8;
	localparam int RES_Q_DEPTH = 2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [63:0] arrival_time_ns;
		logic [31:0] rule_address;
		logic [7:0]  rule_action;
	} in_item_t;

	typedef struct packed {
		logic        verdict;
		logic [2:0]  drop_cause;
		logic        event_valid;
		logic [31:0] event_src_address;
		logic [31:0] event_dst_address;
		logic [15:0] event_src_port;
		logic [15:0] event_dst_port;
		logic [7:0]  event_protocol;
		logic [63:0] event_time_ns;
	} out_item_t;

	typedef enum logic [1:0] {
		JOB_FRAME,
		JOB_RULE_WR,
		JOB_RULE_DEL
	} job_kind_t;

	// Work item handed from the parser to the table engine
	typedef struct packed {
		job_kind_t   kind;
		logic        qualified;
		logic        syn_scan;
		logic        icmp_echo;
		logic [31:0] src;
		logic [31:0] dst;
		logic [31:0] ports;
		logic [63:0] time_ns;
		logic [31:0] rule_address;
		logic [7:0]  rule_action;
	} job_t;

endpackage

>>> src/packet_filter_rate_limit_scan_drop_core.sv
// Top level: packet filter with per-source rate limit and scan drop.
//
//  channel   handshake          payload
//  input     push / full        in_item   (frame byte or rule write/delete)
//  result    empty / pop        out_item  (verdict and scan event)
//  config    cfg_we             cfg_wdata (rate window, ns)
//
// Frame bytes are taken one per cycle while full is low; the parser hands
// a job to the table engine through an 8-deep queue on the last byte, and
// a rule item at once. An IPv4 frame costs a scan of the filled rate
// entries before and after the store and, unless rate-limited, a scan of
// the whole rule table; a rule item costs the rule scan. The cost comes
// from linear scans over the single-port-read tables. After reset a clearing pass over the rule table holds full high.
`timescale 1ns / 1ps

module packet_filter_rate_limit_scan_drop_core #(
	parameter int RATE_ENTRIES = 1024,
	parameter int RULE_ENTRIES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  pfrl_pkg::in_item_t  in_item,
	output logic                empty,
	input  logic                pop,
	output pfrl_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic [39:0]         cfg_wdata
);

	logic                window_q_unused;
	logic [39:0]         window_q;
	logic                accept;
	logic                job_push;
	pfrl_pkg::job_t      job_in;
	pfrl_pkg::job_t      job_out;
	logic                job_full;
	logic                job_empty;
	logic                job_pop;
	logic                res_full;
	logic                res_push;
	pfrl_pkg::out_item_t res;
	logic                clearing;

	assign window_q_unused = 1'b0;
	assign full   = job_full || clearing || window_q_unused;
	assign accept = push && !full;

	// Rate window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= pfrl_pkg::WINDOW_RESET;
		end else if (cfg_we) begin
			window_q <= cfg_wdata;
		end
	end

	pfrl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (in_item),
		.job_push (job_push),
		.job      (job_in)
	);

	pfrl_fifo #(.WIDTH($bits(pfrl_pkg::job_t)), .DEPTH(pfrl_pkg::JOB_Q_DEPTH)) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_in),
		.full   (job_full),
		.pop    (job_pop),
		.rdata  (job_out),
		.empty  (job_empty)
	);

	pfrl_back #(.RATE_ENTRIES(RATE_ENTRIES), .RULE_ENTRIES(RULE_ENTRIES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.window    (window_q),
		.job_empty (job_empty),
		.job       (job_out),
		.job_pop   (job_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res),
		.clearing  (clearing)
	);

	pfrl_fifo #(.WIDTH($bits(pfrl_pkg::out_item_t)), .DEPTH(pfrl_pkg::RES_Q_DEPTH)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (out_item),
		.empty  (empty)
	);

	// A job never meets a full queue
	a_job_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !job_full)
		else $error("job pushed into full queue");

	// No result can exist before the rule table is cleared
	a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> empty)
		else $error("result present during clearing pass");

	// A dropped item always names a cause, a passed one never
	a_verdict_matches_cause: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (res.verdict == (res.drop_cause != pfrl_pkg::CAUSE_NONE)))
		else $error("verdict and drop cause disagree");

	// Engine only pops a job when one is waiting
	a_pop_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> !job_empty)
		else $error("engine popped empty job queue");

endmodule

>>> src/pfrl_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module pfrl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/pfrl_fifo.sv
// Small register FIFO with first-word fall-through.
`timescale 1ns / 1ps

module pfrl_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> src/pfrl_front.sv
// Front end: byte-wise header parser that turns frames and rule items into jobs.
`timescale 1ns / 1ps

module pfrl_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  pfrl_pkg::in_item_t item,
	output logic              job_push,
	output pfrl_pkg::job_t    job
);

	logic [15:0] cnt_q;
	logic [63:0] time_q;
	logic [15:0] eth_q;
	logic [7:0]  vl_q;
	logic [7:0]  proto_q;
	logic [31:0] src_q;
	logic [31:0] dst_q;
	logic [31:0] ports_q;
	logic [7:0]  flag_q;

	logic        first;
	logic [15:0] pos;
	logic [7:0]  b;
	logic [63:0] time_n;
	logic [15:0] eth_c, eth_n;
	logic [7:0]  vl_c, vl_n;
	logic [7:0]  proto_c, proto_n;
	logic [31:0] src_c, src_n;
	logic [31:0] dst_c, dst_n;
	logic [31:0] ports_c, ports_n;
	logic [7:0]  flag_c, flag_n;
	logic [15:0] off;
	logic [15:0] len;
	logic        is_byte;

	assign first   = (cnt_q == '0);
	assign pos     = cnt_q;
	assign b       = item.data_byte;
	assign is_byte = (item.opcode == pfrl_pkg::OP_BYTE);

	// Start of frame clears the captured headers
	assign time_n  = first ? item.arrival_time_ns : time_q;
	assign eth_c   = first ? '0 : eth_q;
	assign vl_c    = first ? '0 : vl_q;
	assign proto_c = first ? '0 : proto_q;
	assign src_c   = first ? '0 : src_q;
	assign dst_c   = first ? '0 : dst_q;
	assign ports_c = first ? '0 : ports_q;
	assign flag_c  = first ? '0 : flag_q;

	// Capture by byte offset
	always_comb begin
		eth_n   = eth_c;
		vl_n    = vl_c;
		proto_n = proto_c;
		src_n   = src_c;
		dst_n   = dst_c;
		ports_n = ports_c;
		flag_n  = flag_c;
		if (pos == pfrl_pkg::POS_ETYPE_HI || pos == pfrl_pkg::POS_ETYPE_LO) begin
			eth_n = {eth_c[7:0], b};
		end
		if (pos == pfrl_pkg::POS_IP_VL) begin
			vl_n = b;
		end
		if (pos == pfrl_pkg::POS_IP_PROTO) begin
			proto_n = b;
		end
		if (pos >= pfrl_pkg::POS_SRC_FIRST && pos <= pfrl_pkg::POS_SRC_LAST) begin
			src_n = {src_c[23:0], b};
		end
		if (pos >= pfrl_pkg::POS_DST_FIRST && pos <= pfrl_pkg::POS_DST_LAST) begin
			dst_n = {dst_c[23:0], b};
		end
		off = pfrl_pkg::POS_IP_VL + {10'd0, vl_n[3:0], 2'b00};
		if (pos >= pfrl_pkg::POS_IP_VL) begin
			if (pos >= off && pos < off + 16'd4) begin
				ports_n = {ports_c[23:0], b};
			end
			if (pos == off) begin
				flag_n = b;
			end
			if (pos == off + pfrl_pkg::TCP_FLAG_OFS && proto_n == pfrl_pkg::PROTO_TCP) begin
				flag_n = b;
			end
		end
	end

	assign len = (cnt_q == pfrl_pkg::COUNT_MAX) ? pfrl_pkg::COUNT_MAX : cnt_q + 16'd1;

	// Job built from the final header view
	always_comb begin
		job              = '0;
		job.src          = src_n;
		job.dst          = dst_n;
		job.ports        = ports_n;
		job.time_ns      = time_n;
		job.rule_address = item.rule_address;
		job.rule_action  = item.rule_action;
		job.qualified    = (len >= pfrl_pkg::MIN_IP_LEN)
			&& (eth_n == pfrl_pkg::ETHERTYPE_IPV4)
			&& (vl_n[7:4] == pfrl_pkg::IP_VERSION_4);
		job.syn_scan     = (proto_n == pfrl_pkg::PROTO_TCP)
			&& (off + pfrl_pkg::TCP_HDR_LEN <= len) && flag_n[1] && !flag_n[4];
		job.icmp_echo    = (proto_n == pfrl_pkg::PROTO_ICMP)
			&& (off + pfrl_pkg::ICMP_HDR_LEN <= len) && (flag_n == pfrl_pkg::ICMP_ECHO_REQ);
		case (item.opcode)
			pfrl_pkg::OP_RULE_WR:  job.kind = pfrl_pkg::JOB_RULE_WR;
			pfrl_pkg::OP_RULE_DEL: job.kind = pfrl_pkg::JOB_RULE_DEL;
			default:               job.kind = pfrl_pkg::JOB_FRAME;
		endcase
	end

	always_comb begin
		case (item.opcode)
			pfrl_pkg::OP_BYTE:     job_push = accept && item.last_byte;
			pfrl_pkg::OP_RULE_WR:  job_push = accept;
			pfrl_pkg::OP_RULE_DEL: job_push = accept;
			default:               job_push = 1'b0;
		endcase
	end

	// Frame byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept && is_byte) begin
			cnt_q <= item.last_byte ? '0 : len;
		end
	end

	// Header capture registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q  <= '0;
			eth_q   <= '0;
			vl_q    <= '0;
			proto_q <= '0;
			src_q   <= '0;
			dst_q   <= '0;
			ports_q <= '0;
			flag_q  <= '0;
		end else if (accept && is_byte) begin
			time_q  <= time_n;
			eth_q   <= eth_n;
			vl_q    <= vl_n;
			proto_q <= proto_n;
			src_q   <= src_n;
			dst_q   <= dst_n;
			ports_q <= ports_n;
			flag_q  <= flag_n;
		end
	end

endmodule

>>> src/pfrl_back.sv
// Back end: rate table with LRU, destination rule table, verdict and event.
`timescale 1ns / 1ps

module pfrl_back #(
	parameter int RATE_ENTRIES = 1024,
	parameter int RULE_ENTRIES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [39:0]        window,
	input  logic               job_empty,
	input  pfrl_pkg::job_t     job,
	output logic               job_pop,
	input  logic               res_full,
	output logic               res_push,
	output pfrl_pkg::out_item_t res,
	output logic               clearing
);

	localparam int RA_AW = (RATE_ENTRIES > 1) ? $clog2(RATE_ENTRIES) : 1;
	localparam int RA_CW = $clog2(RATE_ENTRIES + 1);
	localparam int RU_AW = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
	localparam int RU_CW = $clog2(RULE_ENTRIES + 1);

	typedef struct packed {
		logic [31:0] key;
		logic [63:0] time_ns;
	} rate_word_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] key;
		logic [7:0]  action;
	} rule_word_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RL_SCAN,
		ST_RL_DECIDE,
		ST_RL_TOUCH,
		ST_RU_SCAN,
		ST_RU_FINISH,
		ST_EMIT
	} state_t;

	state_t              state_q;
	pfrl_pkg::job_t      job_q;
	pfrl_pkg::out_item_t res_q;

	// Rate table control
	logic [RA_CW-1:0] ra_fill_q;
	logic [RA_CW-1:0] ra_cnt_q;
	logic             ra_pend_s1;
	logic [RA_AW-1:0] ra_idx_s1;
	logic             hit_q;
	logic [RA_AW-1:0] hit_idx_q;
	logic [63:0]      hit_time_q;
	logic [RA_AW-1:0] hit_rec_q;
	logic [RA_AW-1:0] max_rec_q;
	logic [RA_AW-1:0] max_idx_q;
	logic [RA_AW-1:0] slot_q;
	logic [RA_AW-1:0] below_q;
	logic             all_q;
	logic             limited_q;

	// Rule table control
	logic [RU_CW-1:0] ru_cnt_q;
	logic             ru_pend_s1;
	logic [RU_AW-1:0] ru_idx_s1;
	logic             m_found_q;
	logic [RU_AW-1:0] m_idx_q;
	logic [7:0]       m_act_q;
	logic             f_found_q;
	logic [RU_AW-1:0] f_idx_q;

	// Memory ports
	logic             ra_we;
	logic [RA_AW-1:0] ra_waddr;
	rate_word_t       ra_wdata;
	rate_word_t       ra_rdata;
	logic             rec_we;
	logic [RA_AW-1:0] rec_wdata;
	logic [RA_AW-1:0] rec_rdata;
	logic             ru_we;
	logic [RU_AW-1:0] ru_waddr;
	rule_word_t       ru_wdata;
	rule_word_t       ru_rdata;

	logic [63:0]      elapsed;
	logic             limited_c;
	logic             ra_full;
	logic [RA_AW-1:0] slot_c;
	logic             ra_issue;
	logic             ru_issue;
	logic [31:0]      ru_key_sel;
	logic             ru_match;

	pfrl_ram #(.WIDTH($bits(rate_word_t)), .DEPTH(RATE_ENTRIES)) u_rate_ram (
		.clk   (clk),
		.we    (ra_we),
		.waddr (ra_waddr),
		.wdata (ra_wdata),
		.raddr (ra_cnt_q[RA_AW-1:0]),
		.rdata (ra_rdata)
	);

	pfrl_ram #(.WIDTH(RA_AW), .DEPTH(RATE_ENTRIES)) u_recency_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (ra_idx_s1),
		.wdata (rec_wdata),
		.raddr (ra_cnt_q[RA_AW-1:0]),
		.rdata (rec_rdata)
	);

	pfrl_ram #(.WIDTH($bits(rule_word_t)), .DEPTH(RULE_ENTRIES)) u_rule_ram (
		.clk   (clk),
		.we    (ru_we),
		.waddr (ru_waddr),
		.wdata (ru_wdata),
		.raddr (ru_cnt_q[RU_AW-1:0]),
		.rdata (ru_rdata)
	);

	assign clearing = (state_q == ST_CLEAR);
	assign job_pop  = (state_q == ST_IDLE) && !job_empty;
	assign res_push = (state_q == ST_EMIT) && !res_full;
	assign res      = res_q;

	// Rate decision: elapsed time modulo 2^64 against the window
	assign elapsed   = job_q.time_ns - hit_time_q;
	assign limited_c = hit_q && (elapsed < {24'd0, window});
	assign ra_full   = (ra_fill_q == RA_CW'(RATE_ENTRIES));
	assign slot_c    = hit_q ? hit_idx_q : (ra_full ? max_idx_q : ra_fill_q[RA_AW-1:0]);
	assign ra_issue  = (ra_cnt_q < ra_fill_q);
	assign ru_issue  = (ru_cnt_q < RU_CW'(RULE_ENTRIES));

	assign ru_key_sel = (job_q.kind == pfrl_pkg::JOB_FRAME) ? job_q.dst : job_q.rule_address;
	assign ru_match   = ru_pend_s1 && ru_rdata.valid && (ru_rdata.key == ru_key_sel);

	// Rate table writes: key and time on store, recency during the touch pass
	always_comb begin
		ra_we     = (state_q == ST_RL_DECIDE) && !limited_c;
		ra_waddr  = slot_c;
		ra_wdata  = '{key: job_q.src, time_ns: job_q.time_ns};
		rec_we    = (state_q == ST_RL_TOUCH) && ra_pend_s1
			&& ((ra_idx_s1 == slot_q) || all_q || (rec_rdata < below_q));
		rec_wdata = (ra_idx_s1 == slot_q) ? '0 : rec_rdata + 1'b1;
	end

	// Rule table writes: clear sweep, delete on match, insert or update
	always_comb begin
		ru_we    = 1'b0;
		ru_waddr = ru_cnt_q[RU_AW-1:0];
		ru_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				ru_we = 1'b1;
			end
			ST_RU_SCAN: begin
				ru_we    = ru_match && (job_q.kind == pfrl_pkg::JOB_RULE_DEL);
				ru_waddr = ru_idx_s1;
			end
			ST_RU_FINISH: begin
				ru_we    = (job_q.kind == pfrl_pkg::JOB_RULE_WR) && (m_found_q || f_found_q);
				ru_waddr = m_found_q ? m_idx_q : f_idx_q;
				ru_wdata = '{valid: 1'b1, key: job_q.rule_address, action: job_q.rule_action};
			end
			default: begin
				ru_we = 1'b0;
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			ra_fill_q  <= '0;
			ra_cnt_q   <= '0;
			ra_pend_s1 <= 1'b0;
			ru_cnt_q   <= '0;
			ru_pend_s1 <= 1'b0;
			hit_q      <= 1'b0;
			m_found_q  <= 1'b0;
			f_found_q  <= 1'b0;
			all_q      <= 1'b0;
			limited_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (ru_cnt_q == RU_CW'(RULE_ENTRIES - 1)) begin
						ru_cnt_q <= '0;
						state_q  <= ST_IDLE;
					end else begin
						ru_cnt_q <= ru_cnt_q + 1'b1;
					end
				end

				ST_IDLE: begin
					if (!job_empty) begin
						job_q      <= job;
						ra_cnt_q   <= '0;
						ra_pend_s1 <= 1'b0;
						hit_q      <= 1'b0;
						max_rec_q  <= '0;
						max_idx_q  <= '0;
						ru_cnt_q   <= '0;
						ru_pend_s1 <= 1'b0;
						m_found_q  <= 1'b0;
						f_found_q  <= 1'b0;
						if (job.kind != pfrl_pkg::JOB_FRAME) begin
							state_q <= ST_RU_SCAN;
						end else if (job.qualified) begin
							state_q <= ST_RL_SCAN;
						end else begin
							res_q   <= '0;
							state_q <= ST_EMIT;
						end
					end
				end

				// Key search plus oldest-entry search over the filled part
				ST_RL_SCAN: begin
					ra_pend_s1 <= ra_issue;
					ra_idx_s1  <= ra_cnt_q[RA_AW-1:0];
					if (ra_issue) begin
						ra_cnt_q <= ra_cnt_q + 1'b1;
					end
					if (ra_pend_s1) begin
						if (ra_rdata.key == job_q.src) begin
							hit_q      <= 1'b1;
							hit_idx_q  <= ra_idx_s1;
							hit_time_q <= ra_rdata.time_ns;
							hit_rec_q  <= rec_rdata;
						end
						if (rec_rdata >= max_rec_q) begin
							max_rec_q <= rec_rdata;
							max_idx_q <= ra_idx_s1;
						end
					end
					if (!ra_issue && !ra_pend_s1) begin
						state_q <= ST_RL_DECIDE;
					end
				end

				ST_RL_DECIDE: begin
					limited_q <= limited_c;
					slot_q    <= slot_c;
					below_q   <= hit_q ? hit_rec_q : max_rec_q;
					all_q     <= !hit_q && !ra_full;
					if (!hit_q && !ra_full) begin
						ra_fill_q <= ra_fill_q + 1'b1;
					end
					ra_cnt_q   <= '0;
					ra_pend_s1 <= 1'b0;
					state_q    <= ST_RL_TOUCH;
				end

				// Recency update pass, read then write back in the next cycle
				ST_RL_TOUCH: begin
					ra_pend_s1 <= ra_issue;
					ra_idx_s1  <= ra_cnt_q[RA_AW-1:0];
					if (ra_issue) begin
						ra_cnt_q <= ra_cnt_q + 1'b1;
					end
					if (!ra_issue && !ra_pend_s1) begin
						if (limited_q) begin
							res_q            <= '0;
							res_q.verdict    <= 1'b1;
							res_q.drop_cause <= pfrl_pkg::CAUSE_RATE;
							state_q          <= ST_EMIT;
						end else begin
							state_q <= ST_RU_SCAN;
						end
					end
				end

				// Rule search: first match and first free entry
				ST_RU_SCAN: begin
					ru_pend_s1 <= ru_issue;
					ru_idx_s1  <= ru_cnt_q[RU_AW-1:0];
					if (ru_issue) begin
						ru_cnt_q <= ru_cnt_q + 1'b1;
					end
					if (ru_match && !m_found_q) begin
						m_found_q <= 1'b1;
						m_idx_q   <= ru_idx_s1;
						m_act_q   <= ru_rdata.action;
					end
					if (ru_pend_s1 && !ru_rdata.valid && !f_found_q) begin
						f_found_q <= 1'b1;
						f_idx_q   <= ru_idx_s1;
					end
					if (!ru_issue && !ru_pend_s1) begin
						state_q <= ST_RU_FINISH;
					end
				end

				ST_RU_FINISH: begin
					if (job_q.kind == pfrl_pkg::JOB_FRAME) begin
						res_q <= '0;
						if (m_found_q && (m_act_q == 8'd0)) begin
							res_q.verdict    <= 1'b1;
							res_q.drop_cause <= pfrl_pkg::CAUSE_RULE;
						end else if (job_q.syn_scan) begin
							res_q.verdict           <= 1'b1;
							res_q.drop_cause        <= pfrl_pkg::CAUSE_SYN;
							res_q.event_valid       <= 1'b1;
							res_q.event_src_address <= job_q.src;
							res_q.event_dst_address <= job_q.dst;
							res_q.event_src_port    <= job_q.ports[31:16];
							res_q.event_dst_port    <= job_q.ports[15:0];
							res_q.event_protocol    <= pfrl_pkg::PROTO_TCP;
							res_q.event_time_ns     <= job_q.time_ns;
						end else if (job_q.icmp_echo) begin
							res_q.verdict           <= 1'b1;
							res_q.drop_cause        <= pfrl_pkg::CAUSE_ECHO;
							res_q.event_valid       <= 1'b1;
							res_q.event_src_address <= job_q.src;
							res_q.event_dst_address <= job_q.dst;
							res_q.event_protocol    <= pfrl_pkg::PROTO_ICMP;
							res_q.event_time_ns     <= job_q.time_ns;
						end
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end

				ST_EMIT: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> tb/packet_filter_rate_limit_scan_drop_core_tb.sv
// Testbench for the packet filter core: random frames and rule items checked against a predictor.
`timescale 1ns / 1ps

module packet_filter_rate_limit_scan_drop_core_tb;
	import pfrl_pkg::*;

	localparam int RATE_N = 1024;
	localparam int RULE_N = 1024;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE_CYCLES = 9000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Filter state predictor and store of expected verdicts
	class filter_scoreboard;
		logic [39:0] window;
		int unsigned byte_count;
		logic [63:0] frame_t;
		logic [15:0] etype;
		logic [7:0]  vl;
		logic [7:0]  proto;
		logic [31:0] src;
		logic [31:0] dst;
		logic [31:0] ports;
		logic [7:0]  flag_type;
		logic [31:0] src_key[RATE_N];
		logic [63:0] src_time[RATE_N];
		bit          src_used[RATE_N];
		int unsigned src_age[RATE_N];
		logic [31:0] rule_key[RULE_N];
		logic [7:0]  rule_act[RULE_N];
		bit          rule_used[RULE_N];
		out_item_t   verdicts[$];
		int          failures;

		function new();
			window = WINDOW_RESET;
			byte_count = 0;
			frame_t = '0;
			etype = '0;
			vl = '0;
			proto = '0;
			src = '0;
			dst = '0;
			ports = '0;
			flag_type = '0;
			failures = 0;
			for (int i = 0; i < RATE_N; i++) begin
				src_used[i] = 0;
				src_age[i] = 0;
			end
			for (int i = 0; i < RULE_N; i++)
				rule_used[i] = 0;
		endfunction

		function int pending();
			return verdicts.size();
		endfunction

		// LRU aging: entries younger than the touched one grow older
		function void touch_source(int slot, int unsigned below);
			for (int i = 0; i < RATE_N; i++)
				if (src_used[i] && i != slot && src_age[i] < below)
					src_age[i]++;
			src_age[slot] = 0;
		endfunction

		function bit rate_limited(logic [31:0] key, logic [63:0] now);
			int victim;
			int unsigned oldest;
			bit got_free;
			bit lim;
			logic [63:0] elapsed;
			victim = 0;
			oldest = 0;
			got_free = 0;
			for (int i = 0; i < RATE_N; i++) begin
				if (src_used[i] && src_key[i] == key) begin
					elapsed = now - src_time[i];
					lim = elapsed < {24'd0, window};
					if (!lim)
						src_time[i] = now;
					touch_source(i, src_age[i]);
					return lim;
				end
			end
			for (int i = 0; i < RATE_N; i++) begin
				if (!src_used[i]) begin
					victim = i;
					got_free = 1;
					break;
				end
				if (src_age[i] >= oldest) begin
					oldest = src_age[i];
					victim = i;
				end
			end
			src_used[victim] = 1;
			src_key[victim] = key;
			src_time[victim] = now;
			touch_source(victim, got_free ? 32'hFFFF_FFFF : oldest);
			return 0;
		endfunction

		function void rule_write(logic [31:0] key, logic [7:0] act);
			for (int i = 0; i < RULE_N; i++)
				if (rule_used[i] && rule_key[i] == key) begin
					rule_act[i] = act;
					return;
				end
			for (int i = 0; i < RULE_N; i++)
				if (!rule_used[i]) begin
					rule_used[i] = 1;
					rule_key[i] = key;
					rule_act[i] = act;
					return;
				end
		endfunction

		function void rule_delete(logic [31:0] key);
			for (int i = 0; i < RULE_N; i++)
				if (rule_used[i] && rule_key[i] == key)
					rule_used[i] = 0;
		endfunction

		function bit rule_blocks(logic [31:0] key);
			for (int i = 0; i < RULE_N; i++)
				if (rule_used[i] && rule_key[i] == key)
					return rule_act[i] == 8'd0;
			return 0;
		endfunction

		// Header capture by byte position
		function void grab(int unsigned pos, logic [7:0] b);
			int unsigned off;
			if (pos == 12 || pos == 13)
				etype = {etype[7:0], b};
			if (pos == 14)
				vl = b;
			if (pos == 23)
				proto = b;
			if (pos >= 26 && pos <= 29)
				src = {src[23:0], b};
			if (pos >= 30 && pos <= 33)
				dst = {dst[23:0], b};
			off = 14 + 4 * vl[3:0];
			if (pos < 14)
				return;
			if (pos >= off && pos < off + 4)
				ports = {ports[23:0], b};
			if (pos == off)
				flag_type = b;
			if (pos == off + 13 && proto == PROTO_TCP)
				flag_type = b;
		endfunction

		function void note_item(in_item_t it);
			int unsigned len;
			int unsigned off;
			out_item_t v;
			case (it.opcode)
				OP_RULE_WR: rule_write(it.rule_address, it.rule_action);
				OP_RULE_DEL: rule_delete(it.rule_address);
				OP_BYTE: begin
					if (byte_count == 0) begin
						frame_t = it.arrival_time_ns;
						etype = '0;
						vl = '0;
						proto = '0;
						src = '0;
						dst = '0;
						ports = '0;
						flag_type = '0;
					end
					grab(byte_count, it.data_byte);
					if (byte_count < 65535)
						byte_count++;
					if (it.last_byte) begin
						len = byte_count;
						byte_count = 0;
						off = 14 + 4 * vl[3:0];
						v = '0;
						v.drop_cause = CAUSE_NONE;
						if (len >= 34 && etype == ETHERTYPE_IPV4 && vl[7:4] == IP_VERSION_4) begin
							if (rate_limited(src, frame_t))
								v.drop_cause = CAUSE_RATE;
							else if (rule_blocks(dst))
								v.drop_cause = CAUSE_RULE;
							else if (proto == PROTO_TCP) begin
								if (off + 20 <= len && flag_type[1] && !flag_type[4])
									v.drop_cause = CAUSE_SYN;
							end else if (proto == PROTO_ICMP) begin
								if (off + 8 <= len && flag_type == ICMP_ECHO_REQ)
									v.drop_cause = CAUSE_ECHO;
							end
						end
						v.verdict = v.drop_cause != CAUSE_NONE;
						if (v.drop_cause == CAUSE_SYN || v.drop_cause == CAUSE_ECHO) begin
							v.event_valid = 1'b1;
							v.event_src_address = src;
							v.event_dst_address = dst;
							if (v.drop_cause == CAUSE_SYN) begin
								v.event_src_port = ports[31:16];
								v.event_dst_port = ports[15:0];
								v.event_protocol = PROTO_TCP;
							end else
								v.event_protocol = PROTO_ICMP;
							v.event_time_ns = frame_t;
						end
						verdicts.push_back(v);
					end
				end
				default: ;
			endcase
		endfunction

		function void field(string name, logic [63:0] e, logic [63:0] a);
			if (e !== a) begin
				$error("%s: expected %0h, got %0h", name, e, a);
				failures++;
			end
		endfunction

		function void check_result(out_item_t a);
			out_item_t e;
			if (verdicts.size() == 0) begin
				$error("verdict with none expected: %p", a);
				failures++;
				return;
			end
			e = verdicts.pop_front();
			field("verdict", e.verdict, a.verdict);
			field("drop_cause", e.drop_cause, a.drop_cause);
			field("event_valid", e.event_valid, a.event_valid);
			field("event_src_address", e.event_src_address, a.event_src_address);
			field("event_dst_address", e.event_dst_address, a.event_dst_address);
			field("event_src_port", e.event_src_port, a.event_src_port);
			field("event_dst_port", e.event_dst_port, a.event_dst_port);
			field("event_protocol", e.event_protocol, a.event_protocol);
			field("event_time_ns", e.event_time_ns, a.event_time_ns);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	in_item_t    in_item;
	logic        empty;
	logic        pop;
	out_item_t   out_item;
	logic        cfg_we;
	logic [39:0] cfg_wdata;

	filter_scoreboard sb;
	int send_idle;
	int recv_idle;
	int hold_left;
	int side_rate;      // per-mille chance of a rule item or unused opcode inside a frame
	logic [63:0] now_ns;
	logic [31:0] src_pool[6];
	logic [31:0] dst_pool[6];

	packet_filter_rate_limit_scan_drop_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.empty    (empty),
		.pop      (pop),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Timeout
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	// Result side: random pop, with a long hold-off on request
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				pop = 1'b0;
			end else
				pop = $urandom_range(99) >= recv_idle;
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_result(out_item);
	end

	// Offer one item, with random idle cycles ahead of it
	task automatic send(in_item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		in_item = it;
		do
			@(posedge clk);
		while (full);
		sb.note_item(it);
	endtask

	task automatic send_rule(logic [1:0] op, logic [31:0] addr, logic [7:0] act);
		in_item_t it;
		it = '0;
		it.opcode = op;
		it.data_byte = $urandom;
		it.last_byte = $urandom;
		it.arrival_time_ns = {$urandom, $urandom};
		it.rule_address = addr;
		it.rule_action = act;
		send(it);
	endtask

	// Rule writes, deletes or an unused opcode slipped in between bytes
	task automatic maybe_side_item();
		if ($urandom_range(999) < side_rate) begin
			case ($urandom_range(2))
				0: send_rule(OP_RULE_WR, dst_pool[$urandom_range(5)], $urandom_range(1) ? 8'd0 : $urandom);
				1: send_rule(OP_RULE_DEL, dst_pool[$urandom_range(5)], $urandom);
				default: send_rule(OP_UNUSED, $urandom, $urandom);
			endcase
		end
	endtask

	// Build a frame from header fields and stream it byte by byte
	task automatic send_frame(logic [15:0] et, logic [7:0] verlen, logic [7:0] pr,
			logic [31:0] s, logic [31:0] d, logic [31:0] prt, logic [7:0] ft,
			int len, logic [63:0] t);
		logic [7:0] fr[];
		int off;
		in_item_t it;
		fr = new[len];
		foreach (fr[i])
			fr[i] = $urandom;
		off = 14 + 4 * verlen[3:0];
		for (int i = 0; i < 4; i++)
			if (off + i < len)
				fr[off + i] = prt[31 - 8 * i -: 8];
		if (pr == PROTO_TCP) begin
			if (off + 13 < len)
				fr[off + 13] = ft;
		end else if (off < len)
			fr[off] = ft;
		if (len > 13) begin
			fr[12] = et[15:8];
			fr[13] = et[7:0];
		end
		if (len > 14)
			fr[14] = verlen;
		if (len > 23)
			fr[23] = pr;
		for (int i = 0; i < 4; i++) begin
			if (26 + i < len)
				fr[26 + i] = s[31 - 8 * i -: 8];
			if (30 + i < len)
				fr[30 + i] = d[31 - 8 * i -: 8];
		end
		for (int i = 0; i < len; i++) begin
			it = '0;
			it.opcode = OP_BYTE;
			it.data_byte = fr[i];
			it.last_byte = i == len - 1;
			it.arrival_time_ns = i == 0 ? t : {$urandom, $urandom};
			it.rule_address = $urandom;
			it.rule_action = $urandom;
			send(it);
			if (i != len - 1)
				maybe_side_item();
		end
	endtask

	// Let the block drain, including rule jobs that give no verdict
	task automatic settle();
		@(negedge clk);
		push = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(logic [39:0] v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_wdata = $urandom;
		sb.window = v;
	endtask

	// One random frame: mostly well-formed TCP or ICMP, some noise
	task automatic random_frame();
		logic [31:0] s;
		logic [31:0] d;
		logic [7:0] verlen;
		logic [7:0] ft;
		logic [7:0] pr;
		logic [15:0] et;
		int len;
		int sel;
		int off;
		case ($urandom_range(3))
			0: now_ns = now_ns + $urandom_range(2000);
			1: now_ns = now_ns + ({$urandom, $urandom} & 64'hFF_FFFF_FFFF);
			2: now_ns = now_ns + {$urandom, $urandom};
			default: now_ns = now_ns + (sb.window >> $urandom_range(2));
		endcase
		s = $urandom_range(9) == 0 ? $urandom : src_pool[$urandom_range(5)];
		d = $urandom_range(9) == 0 ? $urandom : dst_pool[$urandom_range(5)];
		et = ETHERTYPE_IPV4;
		verlen = {IP_VERSION_4, 4'd5};
		if ($urandom_range(5) == 0)
			verlen[3:0] = $urandom;
		pr = $urandom_range(1) ? PROTO_TCP : PROTO_ICMP;
		ft = $urandom;
		if (pr == PROTO_TCP && $urandom_range(1))
			ft = {3'b000, 1'($urandom), 2'b00, 1'b1, 1'($urandom)};
		if (pr == PROTO_ICMP && $urandom_range(1))
			ft = ICMP_ECHO_REQ;
		off = 14 + 4 * verlen[3:0];
		len = off + (pr == PROTO_TCP ? 20 : 8) + $urandom_range(6);
		if (len < 34)
			len = 34 + $urandom_range(4);
		sel = $urandom_range(99);
		if (sel < 8)
			et = $urandom;
		else if (sel < 14)
			verlen[7:4] = $urandom;
		else if (sel < 20)
			len = $urandom_range(1, 33);
		else if (sel < 28)
			len = $urandom_range(34, len - 1);
		else if (sel < 34)
			pr = $urandom;
		send_frame(et, verlen, pr, s, d, $urandom, ft, len, now_ns);
	endtask

	task automatic random_phase(int frames);
		for (int n = 0; n < frames; n++) begin
			if ($urandom_range(99) < 15)
				send_rule($urandom_range(1) ? OP_RULE_WR : OP_RULE_DEL, dst_pool[$urandom_range(5)],
					$urandom_range(2) == 0 ? 8'd0 : $urandom);
			random_frame();
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		push = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		hold_left = 0;
		side_rate = 2;
		send_idle = 6;
		recv_idle = 80;
		now_ns = 64'd5000;
		src_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hC0A8_0001, 32'h0A00_0002,
			32'h5A5A_A5A5, 32'h8000_0001};
		dst_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hC0A8_0102, 32'h0A0B_0C0D,
			32'hA5A5_5A5A, 32'h7F00_0001};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: scan drops, passes, malformed frames, rules, rate window
		send_frame(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 32'h0102_0304, 32'hC0A8_0102,
			32'hFFFF_0000, 8'h02, 54, 64'd100);
		send_frame(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 32'h0102_0305, 32'hC0A8_0102,
			32'h1234_0050, 8'h12, 54, 64'd200);
		send_frame(ETHERTYPE_IPV4, 8'h45, PROTO_ICMP, 32'h0102_0306, 32'hFFFF_FFFF,
			32'h0, ICMP_ECHO_REQ, 42, 64'hFFFF_FFFF_FFFF_FFFF);
		send_frame(ETHERTYPE_IPV4, 8'h45, PROTO_ICMP, 32'h0102_0307, 32'h0,
			32'h0, 8'h00, 42, 64'd300);
		send_frame(16'h86DD, 8'h45, PROTO_TCP, 32'h0102_0308, 32'h0, 32'h0, 8'h02, 60, 64'd1);
		send_frame(ETHERTYPE_IPV4, 8'h65, PROTO_TCP, 32'h0102_0309, 32'h0, 32'h0, 8'h02, 60, 64'd1);
		send_frame(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 32'h0102_030A, 32'h0, 32'h0, 8'h02, 33, 64'd1);
		send_frame(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 32'h0102_030B, 32'h0, 32'h0, 8'h02, 53, 64'd1);
		send_frame(ETHERTYPE_IPV4, 8'h43, PROTO_TCP, 32'h0102_030C, 32'h0, 32'h0, 8'h02, 46, 64'd1);
		send_frame(ETHERTYPE_IPV4, 8'h4F, PROTO_ICMP, 32'h0102_030D, 32'h0, 32'h0,
			ICMP_ECHO_REQ, 82, 64'd1);
		// rule drop, rewrite to allow, delete, delete of an absent key
		send_rule(OP_RULE_WR, 32'hA5A5_5A5A, 8'd0);
		send_frame(ETHERTYPE_IPV4, 8'h45, PROTO_ICMP, 32'h0102_030E, 32'hA5A5_5A5A, 32'h0,
			ICMP_ECHO_REQ, 42, 64'd1);
		send_rule(OP_RULE_WR, 32'hA5A5_5A5A, 8'hFF);
		send_frame(ETHERTYPE_IPV4, 8'h45, PROTO_ICMP, 32'h0102_030F, 32'hA5A5_5A5A, 32'h0,
			ICMP_ECHO_REQ, 42, 64'd1);
		send_rule(OP_RULE_DEL, 32'hA5A5_5A5A, 8'd0);
		send_rule(OP_RULE_DEL, 32'h1111_1111, 8'd0);
		send_rule(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF);
		// repeat source: first frame, one short of the window, then exactly at it
		send_frame(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 32'hDEAD_BEEF, 32'h0, 32'h0, 8'h10, 54,
			64'd1000);
		send_frame(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 32'hDEAD_BEEF, 32'h0, 32'h0, 8'h10, 54,
			64'd1000 + WINDOW_RESET - 1);
		send_frame(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 32'hDEAD_BEEF, 32'h0, 32'h0, 8'h10, 54,
			64'd1000 + WINDOW_RESET);
		// rule and unused items in mid-frame
		side_rate = 150;
		send_frame(ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 32'h0102_0310, 32'hC0A8_0102,
			32'h0, 8'h02, 54, 64'd7);
		side_rate = 2;
		// byte count saturation
		send_frame(ETHERTYPE_IPV4, 8'h45, PROTO_ICMP, 32'h0102_0311, 32'h0, 32'h0,
			ICMP_ECHO_REQ, 65600, 64'd9);
		settle();

		// Phase 1: window zero, sender mostly busy, receiver mostly stalled
		write_window(40'd0);
		random_phase(20);
		settle();

		// Phase 2: widest window, idling swapped
		send_idle = 80;
		recv_idle = 6;
		write_window(40'hFF_FFFF_FFFF);
		random_phase(20);
		settle();

		// Phase 3: small window, no idling, long receiver hold to fill the block
		send_idle = 0;
		recv_idle = 0;
		write_window($urandom_range(1, 5000));
		@(posedge clk);
		hold_left = 30000;
		random_phase(25);
		settle();

		if (sb.pending() != 0) begin
			$error("%0d verdicts never arrived", sb.pending());
			sb.failures++;
		end
		if (sb.failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
